[rtl/plc_pkg.sv]
// plc_pkg: shared constants, codes, heat color table and status types for the
// value-to-color palette lookup. Used by every module in rtl/.
package plc_pkg;

	localparam int SLOTS_DEF    = 100;
	localparam int HEAT_ENTRIES = 100;
	localparam int SPAN_MIN     = 7;
	localparam logic [7:0] GRAY_CH = 8'h80;

	localparam logic [1:0] MODE_SET    = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_BUILD  = 2'd2;
	localparam logic [1:0] MODE_LOOKUP = 2'd3;

	localparam logic [1:0] CHOICE_HEAT   = 2'd0;
	localparam logic [1:0] CHOICE_STRIPE = 2'd1;
	localparam logic [1:0] CHOICE_GRAD   = 2'd2;

	localparam logic [1:0] REG_LOW    = 2'd0;
	localparam logic [1:0] REG_SPAN   = 2'd1;
	localparam logic [1:0] REG_CHOICE = 2'd2;

	localparam logic [31:0] SPAN_RESET = 32'h0001_0000;

	typedef struct packed {
		logic done;
		logic ok;
	} idx_stat_t;

	localparam logic [23:0] HEAT_ROM [HEAT_ENTRIES] = '{
		24'h0000FF, 24'h000BFF, 24'h0015FF, 24'h001FFF, 24'h0029FF, 24'h0033FF, 24'h003DFF,
		24'h0048FF, 24'h0052FF, 24'h005DFF, 24'h0067FF, 24'h0071FF, 24'h007CFF, 24'h0086FF,
		24'h0090FF, 24'h009BFF, 24'h00A5FF, 24'h00AFFF, 24'h00B9FF, 24'h00C4FF, 24'h00CFFF,
		24'h00D8FF, 24'h00E3FF, 24'h00EDFF, 24'h00F7FF, 24'h00FFFD, 24'h00FFF2, 24'h00FFE8,
		24'h00FFDD, 24'h00FFD3, 24'h00FFC9, 24'h00FFBF, 24'h00FFB5, 24'h00FFAA, 24'h00FFA0,
		24'h00FF96, 24'h00FF8B, 24'h00FF81, 24'h00FF77, 24'h00FF6C, 24'h00FF62, 24'h00FF57,
		24'h00FF4D, 24'h00FF43, 24'h00FF39, 24'h00FF2E, 24'h00FF24, 24'h00FF19, 24'h00FF0F,
		24'h00FF05, 24'h05FF00, 24'h0FFF00, 24'h1AFF00, 24'h24FF00, 24'h2FFF00, 24'h38FF00,
		24'h43FF00, 24'h4EFF00, 24'h58FF00, 24'h62FF00, 24'h6CFF00, 24'h76FF00, 24'h80FF00,
		24'h8BFF00, 24'h95FF00, 24'hA0FF00, 24'hAAFF00, 24'hB4FF00, 24'hBFFF00, 24'hC8FF00,
		24'hD4FF00, 24'hDEFF00, 24'hE8FF00, 24'hF2FF00, 24'hFCFF00, 24'hFFF800, 24'hFFED00,
		24'hFFE200, 24'hFFD900, 24'hFFCE00, 24'hFFC400, 24'hFFB900, 24'hFFAF00, 24'hFFA500,
		24'hFF9B00, 24'hFF9000, 24'hFF8600, 24'hFF7C00, 24'hFF7100, 24'hFF6700, 24'hFF5D00,
		24'hFF5300, 24'hFF4900, 24'hFF3E00, 24'hFF3300, 24'hFF2900, 24'hFF1F00, 24'hFF1500,
		24'hFF0A00, 24'hFF0000
	};

endpackage

[rtl/plc_index.sv]
// plc_index: sample to palette index, trunc((SLOTS-1)*(sample-low)/span),
// one quotient bit per cycle. Depends on plc_pkg.
module plc_index #(
	parameter int SLOTS = plc_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [31:0]         sample,
	input  logic signed [31:0]         low_limit,
	input  logic signed [31:0]         span,
	output plc_pkg::idx_stat_t         stat,
	output logic [$clog2(SLOTS)-1:0]   idx
);
	import plc_pkg::*;

	localparam int IDXW = $clog2(SLOTS);
	localparam int PW   = 33 + IDXW;
	localparam int MW   = 32 + IDXW;
	localparam int CW   = $clog2(IDXW + 1);

	typedef enum logic [1:0] {I_IDLE, I_ABS, I_DIV} ist_t;

	ist_t                  st_q;
	logic signed [PW-1:0]  prod_s1;
	logic                  span_ok_s1;
	logic [31:0]           rem_q;
	logic [IDXW-1:0]       lo_q;
	logic                  neg_q;
	logic                  bad_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic                  ok_q;
	logic [IDXW-1:0]       idx_q;

	logic signed [32:0]    diff;
	logic signed [PW-1:0]  dext;
	logic signed [PW-1:0]  prod_c;
	logic                  neg;
	logic [PW-1:0]         mag;
	logic [31:0]           hi;
	logic [31:0]           dv;
	logic [32:0]           t;
	logic                  ge;
	logic [32:0]           tsub;
	logic [IDXW-1:0]       q_next;

	assign diff   = {sample[31], sample} - {low_limit[31], low_limit};
	assign dext   = {{IDXW{diff[32]}}, diff};
	assign prod_c = dext * $signed(PW'(SLOTS - 1));
	assign neg    = prod_s1[PW-1];
	assign mag    = neg ? PW'(-prod_s1) : PW'(prod_s1);
	assign hi     = mag[MW-1:IDXW];
	assign dv     = span;
	assign t      = {rem_q, lo_q[IDXW-1]};
	assign ge     = t >= {1'b0, dv};
	assign tsub   = t - {1'b0, dv};
	assign q_next = (lo_q << 1) | IDXW'(ge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= I_IDLE;
			prod_s1    <= '0;
			span_ok_s1 <= 1'b0;
			rem_q      <= '0;
			lo_q       <= '0;
			neg_q      <= 1'b0;
			bad_q      <= 1'b0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			ok_q       <= 1'b0;
			idx_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				I_IDLE: begin
					if (start) begin
						prod_s1    <= prod_c;
						span_ok_s1 <= span >= SPAN_MIN;
						st_q       <= I_ABS;
					end
				end
				I_ABS: begin
					// quotient must fit the index width, else out of range
					rem_q <= hi;
					lo_q  <= mag[IDXW-1:0];
					neg_q <= neg;
					bad_q <= !span_ok_s1 || (hi >= dv);
					cnt_q <= '0;
					st_q  <= I_DIV;
				end
				I_DIV: begin
					rem_q <= ge ? tsub[31:0] : t[31:0];
					lo_q  <= q_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(IDXW - 1)) begin
						done_q <= 1'b1;
						idx_q  <= q_next;
						// negative offsets only land on slot 0 when they truncate to zero
						ok_q   <= !bad_q && (neg_q ? (q_next == '0)
							: ({1'b0, q_next} <= (IDXW+1)'(SLOTS - 1)));
						st_q   <= I_IDLE;
					end
				end
				default: st_q <= I_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.ok   = ok_q;
	assign idx       = idx_q;

endmodule

[rtl/plc_mix.sv]
// plc_mix: rounded linear blend of two colors, (x*(d-k)+y*k+d/2)/d per channel,
// three channels side by side, one quotient bit per cycle. Depends on plc_pkg.
module plc_mix #(
	parameter int SLOTS = plc_pkg::SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [23:0]               ca,
	input  logic [23:0]               cb,
	input  logic [$clog2(SLOTS)-1:0]  k,
	input  logic [$clog2(SLOTS)-1:0]  d,
	output logic                      done,
	output logic [23:0]               color
);
	import plc_pkg::*;

	localparam int IDXW = $clog2(SLOTS);
	localparam int NW   = 8 + IDXW;

	logic            busy_q;
	logic [2:0]      cnt_q;
	logic            done_q;
	logic [IDXW-1:0] rem_q [3];
	logic [7:0]      lo_q  [3];

	logic [NW-1:0]   num_c [3];
	logic [IDXW:0]   t     [3];
	logic            ge    [3];
	logic [IDXW:0]   tsub  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_c[c] = NW'(ca[8*c +: 8]) * NW'(d - k) + NW'(cb[8*c +: 8]) * NW'(k)
				+ NW'(d >> 1);
			t[c]     = {rem_q[c], lo_q[c][7]};
			ge[c]    = t[c] >= {1'b0, d};
			tsub[c]  = t[c] - {1'b0, d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= '0;
				lo_q[c]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// blend is below 256*d, so the top part starts below the divisor
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= num_c[c][NW-1:8];
					lo_q[c]  <= num_c[c][7:0];
				end
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= ge[c] ? tsub[c][IDXW-1:0] : t[c][IDXW-1:0];
					lo_q[c]  <= {lo_q[c][6:0], ge[c]};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign color = {lo_q[2], lo_q[1], lo_q[0]};

endmodule

[rtl/value_to_color_palette_lookup.sv]
// value_to_color_palette_lookup: top level, palette memories and command sequencer.
// Depends on plc_pkg, plc_index, plc_mix.
//
// A command is taken when start is high and busy is low; busy stays high until the
// command is finished. Only a lookup gives a result: done is high for one cycle with
// the color, and the receiver cannot stall it. A lookup runs through the index divider,
// which resolves one quotient bit per cycle. Set-slot and clear commands finish in the
// cycle they are taken. A build scans the slots one per cycle; for each slot below the
// last it loads a blend, runs an eight-step divide per blended color and writes both
// memories. Configuration is always ready; it must be written only while idle, which
// the block itself does not enforce.
module value_to_color_palette_lookup #(
	parameter int SLOTS = plc_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [6:0]         slot,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic signed [31:0] sample,
	output logic               done,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic               fallback_gray,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import plc_pkg::*;

	localparam int IDXW = $clog2(SLOTS);
	localparam int EXTW = IDXW + 7;
	localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LU_WAIT, ST_LU_OUT, ST_BF_FIRST, ST_BF_FIRSTD,
		ST_BF_NEXT, ST_BF_BD, ST_BF_MIX, ST_BF_LAST
	} st_t;

	st_t st_q;

	logic signed [31:0] low_q;
	logic signed [31:0] span_q;
	logic [1:0]         choice_q;
	logic signed [31:0] sample_q;

	logic [SLOTS-1:0]   sset_q;
	logic [SLOTS-1:0]   gset_q;

	logic [23:0] smem [SLOTS];
	logic [23:0] gmem [SLOTS];
	logic [23:0] s_rdata;
	logic [23:0] g_rdata;

	logic            s_we, s_re, g_we, g_re;
	logic [IDXW-1:0] s_waddr, s_raddr, g_waddr, g_raddr;
	logic [23:0]     s_wdata, g_wdata;

	logic            idx_go_q;
	idx_stat_t       istat;
	logic [IDXW-1:0] iidx;

	logic            mix_go_q;
	logic            mix_done;
	logic [23:0]     mix_color;

	logic [IDXW-1:0] p_q, a_q, b_q, i_q;
	logic [23:0]     ca_q, cb_q;
	logic            bset_q;

	logic            ok_q, sbit_q, gbit_q;
	logic [IDXW-1:0] lidx_q;

	logic            done_q, gray_q;
	logic [23:0]     color_q;

	logic [EXTW-1:0] slot_x;
	logic            slot_ok;
	logic [IDXW-1:0] slot_a;
	logic [EXTW-1:0] heat_x;
	logic            in_heat;
	logic            hit;
	logic [23:0]     hit_color;

	assign slot_x  = EXTW'(slot);
	assign slot_ok = slot_x < EXTW'(SLOTS);
	assign slot_a  = slot_x[IDXW-1:0];
	assign heat_x  = EXTW'(lidx_q);
	assign in_heat = heat_x < EXTW'(HEAT_ENTRIES);

	plc_index #(.SLOTS(SLOTS)) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (idx_go_q),
		.sample    (sample_q),
		.low_limit (low_q),
		.span      (span_q),
		.stat      (istat),
		.idx       (iidx)
	);

	plc_mix #(.SLOTS(SLOTS)) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_go_q),
		.ca     (ca_q),
		.cb     (cb_q),
		.k      (i_q - a_q),
		.d      (b_q - a_q),
		.done   (mix_done),
		.color  (mix_color)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sample_q <= sample;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_waddr] <= s_wdata;
		end
		if (s_re) begin
			s_rdata <= smem[s_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[g_waddr] <= g_wdata;
		end
		if (g_re) begin
			g_rdata <= gmem[g_raddr];
		end
	end

	always_comb begin
		s_we    = 1'b0;
		s_waddr = i_q;
		s_wdata = ca_q;
		s_re    = 1'b0;
		s_raddr = p_q;
		g_we    = 1'b0;
		g_waddr = i_q;
		g_wdata = mix_color;
		g_re    = 1'b0;
		g_raddr = iidx;
		case (st_q)
			ST_IDLE: begin
				if (start && mode == MODE_SET && slot_ok) begin
					s_we    = 1'b1;
					s_waddr = slot_a;
					s_wdata = {red_in, green_in, blue_in};
				end
			end
			ST_LU_WAIT: begin
				if (istat.done && istat.ok) begin
					s_re    = 1'b1;
					s_raddr = iidx;
					g_re    = 1'b1;
				end
			end
			ST_BF_FIRST: begin
				s_re = sset_q[p_q];
			end
			ST_BF_NEXT: begin
				s_re = sset_q[p_q] || (p_q == LAST);
			end
			ST_BF_MIX: begin
				s_we = mix_done;
				g_we = mix_done;
			end
			ST_BF_LAST: begin
				s_we    = 1'b1;
				s_waddr = LAST;
				s_wdata = cb_q;
				g_we    = 1'b1;
				g_waddr = LAST;
				g_wdata = cb_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (choice_q)
			CHOICE_STRIPE: begin
				hit       = ok_q && sbit_q;
				hit_color = s_rdata;
			end
			CHOICE_GRAD: begin
				hit       = ok_q && gbit_q;
				hit_color = g_rdata;
			end
			default: begin
				hit       = ok_q && in_heat;
				hit_color = HEAT_ROM[heat_x[6:0]];
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			span_q   <= SPAN_RESET;
			choice_q <= CHOICE_HEAT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW:    low_q    <= cfg_data;
				REG_SPAN:   span_q   <= cfg_data;
				REG_CHOICE: choice_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			sset_q   <= '0;
			gset_q   <= '0;
			idx_go_q <= 1'b0;
			mix_go_q <= 1'b0;
			p_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			i_q      <= '0;
			ca_q     <= '0;
			cb_q     <= '0;
			bset_q   <= 1'b0;
			ok_q     <= 1'b0;
			sbit_q   <= 1'b0;
			gbit_q   <= 1'b0;
			lidx_q   <= '0;
			done_q   <= 1'b0;
			gray_q   <= 1'b0;
			color_q  <= '0;
		end else begin
			idx_go_q <= 1'b0;
			mix_go_q <= 1'b0;
			done_q   <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						case (mode)
							MODE_SET: begin
								if (slot_ok) begin
									sset_q[slot_a] <= 1'b1;
								end
							end
							MODE_CLEAR: begin
								sset_q <= '0;
								gset_q <= '0;
							end
							MODE_BUILD: begin
								p_q  <= '0;
								st_q <= ST_BF_FIRST;
							end
							default: begin
								idx_go_q <= 1'b1;
								st_q     <= ST_LU_WAIT;
							end
						endcase
					end
				end
				ST_LU_WAIT: begin
					if (istat.done) begin
						ok_q   <= istat.ok;
						lidx_q <= iidx;
						sbit_q <= sset_q[iidx];
						gbit_q <= gset_q[iidx];
						st_q   <= ST_LU_OUT;
					end
				end
				ST_LU_OUT: begin
					done_q  <= 1'b1;
					gray_q  <= !hit;
					color_q <= hit ? hit_color : {GRAY_CH, GRAY_CH, GRAY_CH};
					st_q    <= ST_IDLE;
				end
				// find the first set slot; with none set the tables stay unset
				ST_BF_FIRST: begin
					if (sset_q[p_q]) begin
						st_q <= ST_BF_FIRSTD;
					end else if (p_q == LAST) begin
						st_q <= ST_IDLE;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_BF_FIRSTD: begin
					ca_q <= s_rdata;
					a_q  <= '0;
					p_q  <= IDXW'(1);
					st_q <= ST_BF_NEXT;
				end
				ST_BF_NEXT: begin
					if (sset_q[p_q] || p_q == LAST) begin
						b_q    <= p_q;
						bset_q <= sset_q[p_q];
						st_q   <= ST_BF_BD;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_BF_BD: begin
					// an unset last slot takes the color held so far
					cb_q     <= bset_q ? s_rdata : ca_q;
					i_q      <= a_q;
					mix_go_q <= 1'b1;
					st_q     <= ST_BF_MIX;
				end
				ST_BF_MIX: begin
					if (mix_done) begin
						sset_q[i_q] <= 1'b1;
						gset_q[i_q] <= 1'b1;
						if (i_q == b_q - 1'b1) begin
							if (b_q == LAST) begin
								st_q <= ST_BF_LAST;
							end else begin
								a_q  <= b_q;
								ca_q <= cb_q;
								p_q  <= b_q + 1'b1;
								st_q <= ST_BF_NEXT;
							end
						end else begin
							i_q      <= i_q + 1'b1;
							mix_go_q <= 1'b1;
						end
					end
				end
				ST_BF_LAST: begin
					sset_q[LAST] <= 1'b1;
					gset_q[LAST] <= 1'b1;
					st_q         <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = st_q != ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign red_out       = color_q[23:16];
	assign green_out     = color_q[15:8];
	assign blue_out      = color_q[7:0];
	assign fallback_gray = gray_q;

endmodule

[test/plc_checker.sv]
// plc_checker: watches command, config and result ports of the palette lookup,
// predicts each lookup color and compares it. Depends on plc_pkg.
`timescale 1ns / 100ps
module plc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic [6:0]         slot,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic signed [31:0] sample,
	input  logic               done,
	input  logic [7:0]         red_out,
	input  logic [7:0]         green_out,
	input  logic [7:0]         blue_out,
	input  logic               fallback_gray,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending_colors
);
	import plc_pkg::*;

	typedef struct packed {
		logic [23:0] rgb;
		logic        gray;
	} color_t;

	localparam int N = SLOTS_DEF;

	logic signed [31:0] low_q, span_q;
	logic [1:0]         choice_q;
	logic [23:0]        stripe_rgb [N];
	logic               stripe_ok [N];
	logic [23:0]        grad_rgb [N];
	logic               grad_ok [N];
	color_t             expected_colors [$];

	assign pending_colors = expected_colors.size();

	function automatic logic [7:0] blend(logic [7:0] x, logic [7:0] y, int k, int d);
		int unsigned num;
		num = x * (d - k) + y * k + d / 2;
		return 8'(num / d);
	endfunction

	task automatic rebuild_palettes();
		int a, b, d, k;
		a = 0;
		while (a < N - 1) begin
			b = a + 1;
			while (b < N && !stripe_ok[b]) b++;
			if (a == 0 && b != N && !stripe_ok[0]) begin
				stripe_rgb[0] = stripe_rgb[b];
				stripe_ok[0] = 1'b1;
			end
			if (b == N) begin
				stripe_rgb[N-1] = stripe_rgb[a];
				stripe_ok[N-1] = stripe_ok[a];
				b = N - 1;
			end
			for (int i = a + 1; i < b; i++) begin
				stripe_rgb[i] = stripe_rgb[a];
				stripe_ok[i] = stripe_ok[a];
			end
			d = b - a;
			for (int i = a; i < b; i++) begin
				k = i - a;
				grad_rgb[i] = {blend(stripe_rgb[a][23:16], stripe_rgb[b][23:16], k, d),
					blend(stripe_rgb[a][15:8], stripe_rgb[b][15:8], k, d),
					blend(stripe_rgb[a][7:0], stripe_rgb[b][7:0], k, d)};
				grad_ok[i] = stripe_ok[a];
			end
			a = b;
		end
		grad_rgb[N-1] = stripe_rgb[N-1];
		grad_ok[N-1] = stripe_ok[N-1];
	endtask

	function automatic color_t lookup_color(logic signed [31:0] v);
		color_t c;
		longint diff, idx;
		c.rgb = {3{GRAY_CH}};
		c.gray = 1'b1;
		if (span_q >= SPAN_MIN) begin
			diff = longint'(v) - longint'(low_q);
			idx = (longint'(N - 1) * diff) / longint'(span_q);
			if (idx >= 0 && idx <= N - 1) begin
				if (choice_q == CHOICE_STRIPE) begin
					if (stripe_ok[idx]) begin
						c.rgb = stripe_rgb[idx];
						c.gray = 1'b0;
					end
				end else if (choice_q == CHOICE_GRAD) begin
					if (grad_ok[idx]) begin
						c.rgb = grad_rgb[idx];
						c.gray = 1'b0;
					end
				end else if (idx < HEAT_ENTRIES) begin
					c.rgb = HEAT_ROM[idx];
					c.gray = 1'b0;
				end
			end
		end
		return c;
	endfunction

	initial begin
		fail_count = 0;
		low_q = '0;
		span_q = SPAN_RESET;
		choice_q = CHOICE_HEAT;
		for (int i = 0; i < N; i++) begin
			stripe_rgb[i] = '0;
			stripe_ok[i] = 1'b0;
			grad_rgb[i] = '0;
			grad_ok[i] = 1'b0;
		end
	end

	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			// result check first: a lookup cannot finish in the cycle it is taken
			if (done) begin
				if (expected_colors.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h gray %b",
							{red_out, green_out, blue_out}, fallback_gray);
				end else begin
					want = expected_colors.pop_front();
					if ({red_out, green_out, blue_out} !== want.rgb ||
						fallback_gray !== want.gray) begin
						fail_count++;
						if (fail_count <= 10)
							$display("color exp %h gray %b, got %h gray %b", want.rgb,
								want.gray, {red_out, green_out, blue_out}, fallback_gray);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOW:    low_q = cfg_data;
					REG_SPAN:   span_q = cfg_data;
					REG_CHOICE: choice_q = cfg_data[1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (mode)
					MODE_SET: begin
						if (slot < N) begin
							stripe_rgb[slot] = {red_in, green_in, blue_in};
							stripe_ok[slot] = 1'b1;
						end
					end
					MODE_CLEAR: begin
						for (int i = 0; i < N; i++) begin
							stripe_ok[i] = 1'b0;
							grad_ok[i] = 1'b0;
						end
					end
					MODE_BUILD: rebuild_palettes();
					default: expected_colors.push_back(lookup_color(sample));
				endcase
			end
		end
	end

	final begin
		if (expected_colors.size() != 0) $display("%0d lookups without result",
			expected_colors.size());
	end
endmodule

[test/tb_top.sv]
// tb_top: stimulus and verdict for value_to_color_palette_lookup.
// Depends on plc_pkg, the block and plc_checker.
`timescale 1ns / 100ps
module tb_top;
	import plc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         mode = MODE_LOOKUP;
	logic [6:0]         slot = '0;
	logic [7:0]         red_in = '0, green_in = '0, blue_in = '0;
	logic signed [31:0] sample = '0;
	logic               done;
	logic [7:0]         red_out, green_out, blue_out;
	logic               fallback_gray;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_LOW;
	logic [31:0]        cfg_data = '0;
	int                 fail_count, pending_colors;
	int                 cycle_count = 0;

	always #4 clk = ~clk;

	value_to_color_palette_lookup u_dut (.*);
	plc_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("value_to_color_palette_lookup: mismatch");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// start stays high after the transfer until a gap, a drain or the next command
	task automatic send_cmd(logic [1:0] m, logic [6:0] s, logic [23:0] rgb,
		logic [31:0] v, bit gaps);
		if (gaps) idle_gap();
		mode <= m;
		slot <= s;
		{red_in, green_in, blue_in} <= rgb;
		sample <= v;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_colors != 0) @(posedge clk);
		// builds give no result and can still be running
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_sample(logic [31:0] lo, logic [31:0] sp);
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return lo - $urandom_range(0, 50);
			2: return lo + sp + $urandom_range(0, 50);
			default: return lo + 32'(longint'($urandom()) % (longint'(sp) + 1));
		endcase
	endfunction

	logic [31:0] low_v, span_v;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed: reset palettes, heat ends, unset lookups
		send_cmd(MODE_LOOKUP, 0, 0, 32'h0, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h0001_0000, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h7FFF_FFFF, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h8000_0000, 0);
		send_cmd(MODE_BUILD, 0, 0, 0, 0);
		drain();
		write_reg(REG_CHOICE, CHOICE_STRIPE);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h8000, 0);
		send_cmd(MODE_SET, 7'd127, 24'hFFFFFF, 0, 0);
		send_cmd(MODE_SET, 7'd100, 24'h123456, 0, 0);
		send_cmd(MODE_SET, 7'd99, 24'hFFFFFF, 0, 0);
		send_cmd(MODE_SET, 7'd40, 24'h000000, 0, 0);
		send_cmd(MODE_BUILD, 0, 0, 0, 0);
		drain();
		send_cmd(MODE_LOOKUP, 0, 0, 32'h0, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'hFFFF, 0);
		drain();
		write_reg(REG_CHOICE, CHOICE_GRAD);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h8000, 0);
		drain();
		write_reg(REG_CHOICE, 2'd3);
		write_reg(REG_SPAN, 32'd6);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h0, 0);
		drain();
		write_reg(REG_SPAN, 32'h8000_0000);
		write_reg(REG_LOW, 32'h7FFF_FFFF);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h8000_0000, 0);
		drain();
		write_reg(REG_SPAN, 32'h7FFF_FFFF);
		write_reg(REG_LOW, 32'h8000_0000);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h7FFF_FFFF, 0);
		send_cmd(MODE_LOOKUP, 0, 0, 32'h8000_0000, 0);
		send_cmd(MODE_CLEAR, 0, 0, 0, 0);
		drain();
		// random phases: each writes the configuration, usually rebuilds a palette, then streams mostly lookups
		for (int ph = 0; ph < 14; ph++) begin
			case ($urandom_range(0, 3))
				0: begin low_v = $urandom(); span_v = $urandom(); end
				1: begin low_v = 32'h8000_0000; span_v = 32'd7; end
				default: begin
					low_v = $urandom_range(0, 65535) - 32768;
					span_v = $urandom_range(99, 400000);
				end
			endcase
			write_reg(REG_LOW, low_v);
			write_reg(REG_SPAN, span_v);
			write_reg(REG_CHOICE, 2'($urandom_range(0, 3)));
			if ($urandom_range(0, 3) != 0) send_cmd(MODE_CLEAR, 0, 0, 0, 1);
			repeat ($urandom_range(0, 6))
				send_cmd(MODE_SET, 7'($urandom_range(0, 127)), 24'($urandom()), 0, 1);
			if ($urandom_range(0, 4) != 0) send_cmd(MODE_BUILD, 0, 0, 0, 1);
			for (int i = 0; i < 48; i++) begin
				if (i == 24) begin
					start <= 1'b0;
					while (pending_colors != 0) @(posedge clk);
				end
				if ($urandom_range(0, 29) == 0)
					send_cmd(2'($urandom_range(0, 2)), 7'($urandom_range(0, 127)),
						24'($urandom()), 0, 1);
				else
					send_cmd(MODE_LOOKUP, 0, 0, rand_sample(low_v, span_v),
						$urandom_range(0, 3) == 0);
			end
			drain();
		end
		if (fail_count == 0) begin
			$display("value_to_color_palette_lookup: match");
		end else begin
			$display("value_to_color_palette_lookup: mismatch");
		end
		$finish;
	end
endmodule

[files.f]
rtl/plc_pkg.sv
rtl/plc_index.sv
rtl/plc_mix.sv
rtl/value_to_color_palette_lookup.sv
test/plc_checker.sv
test/tb_top.sv
